>>> design/assert_macros.svh
// assertion macros used by the top-level decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/nec_ir_pkg.sv
package nec_ir_pkg;

   // result kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_NEC    = 2'd1;
   localparam logic [1:0] KIND_REPEAT = 2'd2;
   localparam logic [1:0] KIND_RAW    = 2'd3;

   // which byte the hash round folds in
   localparam logic [1:0] BSEL_CLAMP_LO = 2'd0;
   localparam logic [1:0] BSEL_CLAMP_HI = 2'd1;
   localparam logic [1:0] BSEL_MARK     = 2'd2;
   localparam logic [1:0] BSEL_SPACE    = 2'd3;

   // fnv-1a constants
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       hash_step;
      logic [1:0] byte_sel;
      logic       advance;
      logic       emit;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic first_item;
      logic hash_pulse;
      logic last_item;
   } dp_status_type;

endpackage

>>> design/nec_ir_ctrl.sv
module nec_ir_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  nec_ir_pkg::dp_status_type status,
   output nec_ir_pkg::dp_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_HDR_LO = 3'd1;
   localparam logic [2:0] ST_HDR_HI = 3'd2;
   localparam logic [2:0] ST_MARK   = 3'd3;
   localparam logic [2:0] ST_SPACE  = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // output register can take a new result
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencing of hash rounds and result hand-off
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.first_item) begin
                  state_in = ST_HDR_LO;
               end else if (status.hash_pulse) begin
                  state_in = ST_MARK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_HDR_LO: begin
            cmd.hash_step = 1'b1;
            cmd.byte_sel  = nec_ir_pkg::BSEL_CLAMP_LO;
            state_in      = ST_HDR_HI;
         end
         ST_HDR_HI: begin
            cmd.hash_step = 1'b1;
            cmd.byte_sel  = nec_ir_pkg::BSEL_CLAMP_HI;
            state_in      = status.hash_pulse ? ST_MARK : ST_DONE;
         end
         ST_MARK: begin
            cmd.hash_step = 1'b1;
            cmd.byte_sel  = nec_ir_pkg::BSEL_MARK;
            state_in      = ST_SPACE;
         end
         ST_SPACE: begin
            cmd.hash_step = 1'b1;
            cmd.byte_sel  = nec_ir_pkg::BSEL_SPACE;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!status.last_item) begin
               cmd.advance = 1'b1;
               state_in    = ST_IDLE;
            end else if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid holds until taken
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/nec_ir_dpath.sv
module nec_ir_dpath #(
   parameter int unsigned MAX_PULSES = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [15:0]               req_mark_duration,
   input  logic [15:0]               req_space_duration,
   input  logic [15:0]               req_train_length,
   input  nec_ir_pkg::dp_cmd_type    cmd,
   output nec_ir_pkg::dp_status_type status,
   output logic [1:0]                rsp_code_kind,
   output logic [15:0]               rsp_device_address,
   output logic [7:0]                rsp_command_byte,
   output logic [31:0]               rsp_train_hash
);

   localparam logic [15:0] MAX_P = 16'(MAX_PULSES);

   localparam logic [1:0] LEAD_NONE   = 2'd0;
   localparam logic [1:0] LEAD_REPEAT = 2'd1;
   localparam logic [1:0] LEAD_FRAME  = 2'd2;
   localparam logic [1:0] LEAD_OTHER  = 2'd3;

   // tolerance windows, nominal minus and plus tolerance
   localparam logic [15:0] LEAD_MARK_LO  = 16'd7800;
   localparam logic [15:0] LEAD_MARK_HI  = 16'd10200;
   localparam logic [15:0] REP_SPACE_LO  = 16'd1750;
   localparam logic [15:0] REP_SPACE_HI  = 16'd2750;
   localparam logic [15:0] FRM_SPACE_LO  = 16'd3700;
   localparam logic [15:0] FRM_SPACE_HI  = 16'd5300;
   localparam logic [15:0] SHORT_LO      = 16'd262;
   localparam logic [15:0] SHORT_HI      = 16'd862;
   localparam logic [15:0] LONG_LO       = 16'd1187;
   localparam logic [15:0] LONG_HI       = 16'd2187;
   localparam logic [15:0] LAST_BIT_EDGE = 16'd1100;
   localparam logic [15:0] LAST_BIT_POS  = 16'd32;
   localparam logic [15:0] FRAME_PULSES  = 16'd33;
   localparam logic [15:0] RAW_MIN       = 16'd4;

   // (us + 100) / 200 saturated at 255; /8 then reciprocal of 25
   function automatic logic [7:0] round_sat(input logic [15:0] us);
      logic [16:0] sum;
      logic [13:0] eighth;
      logic [27:0] prod;
      logic [9:0]  quo;
      sum    = {1'b0, us} + 17'd100;
      eighth = sum[16:3];
      prod   = 28'(eighth) * 28'd10486;
      quo    = prod[27:18];
      round_sat = (quo > 10'd255) ? 8'hff : quo[7:0];
   endfunction

   logic [15:0] pos_ff, pos_in;
   logic [15:0] total_ff, total_in;
   logic [1:0]  leader_ff, leader_in;
   logic        good_ff, good_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] hash_ff, hash_in;
   logic [7:0]  mark_byte_ff;
   logic [7:0]  space_byte_ff;
   logic [1:0]  kind_ff;
   logic [15:0] addr_ff;
   logic [7:0]  cmd_byte_ff;
   logic [31:0] out_hash_ff;

   logic        first;
   logic [15:0] total_eff;
   logic [15:0] clamped;
   logic        lead_mark_ok, rep_space_ok, frm_space_ok;
   logic        bit_mark_ok, space_long, space_short;
   logic        bit_active, bit_one, bit_bad;
   logic [4:0]  bit_idx;
   logic [7:0]  hash_byte;
   logic [31:0] hash_mix;
   logic        frame_ok;
   logic [1:0]  kind_in;
   logic [15:0] addr_in;
   logic [7:0]  cmd_byte_in;
   logic [31:0] out_hash_in;

   assign first     = (pos_ff == 16'd0);
   assign total_eff = (req_train_length == 16'd0) ? 16'd1 : req_train_length;
   assign clamped   = (total_ff > MAX_P) ? MAX_P : total_ff;

   // window compares on the incoming pulse
   assign lead_mark_ok = (req_mark_duration >= LEAD_MARK_LO) &&
                         (req_mark_duration <= LEAD_MARK_HI);
   assign rep_space_ok = (req_space_duration >= REP_SPACE_LO) &&
                         (req_space_duration <= REP_SPACE_HI);
   assign frm_space_ok = (req_space_duration >= FRM_SPACE_LO) &&
                         (req_space_duration <= FRM_SPACE_HI);
   assign bit_mark_ok  = (req_mark_duration >= SHORT_LO) &&
                         (req_mark_duration <= SHORT_HI);
   assign space_long   = (req_space_duration >= LONG_LO) &&
                         (req_space_duration <= LONG_HI);
   assign space_short  = (req_space_duration >= SHORT_LO) &&
                         (req_space_duration <= SHORT_HI);

   assign bit_active = !first && (pos_ff <= LAST_BIT_POS) &&
                       (leader_ff == LEAD_FRAME) && good_ff;
   assign bit_idx    = pos_ff[4:0] - 5'd1;

   // bit value; a last-bit space outside both windows is judged against one edge
   always_comb begin
      bit_one = 1'b0;
      bit_bad = 1'b0;
      if (!bit_mark_ok) begin
         bit_bad = 1'b1;
      end else if (space_long) begin
         bit_one = 1'b1;
      end else if (space_short) begin
         bit_one = 1'b0;
      end else if (pos_ff == LAST_BIT_POS) begin
         bit_one = (req_space_duration > LAST_BIT_EDGE);
      end else begin
         bit_bad = 1'b1;
      end
   end

   // leader classification and bit gathering on each request, cleared on emit
   always_comb begin
      leader_in = leader_ff;
      good_in   = good_ff;
      word_in   = word_ff;
      if (cmd.emit) begin
         leader_in = LEAD_NONE;
         good_in   = 1'b0;
         word_in   = '0;
      end else if (cmd.load) begin
         if (first) begin
            word_in = '0;
            good_in = 1'b0;
            if (lead_mark_ok) begin
               if (rep_space_ok) begin
                  leader_in = LEAD_REPEAT;
               end else if (frm_space_ok) begin
                  leader_in = LEAD_FRAME;
                  good_in   = 1'b1;
               end else begin
                  leader_in = LEAD_OTHER;
               end
            end else begin
               leader_in = LEAD_NONE;
            end
         end else if (bit_active) begin
            if (bit_bad) begin
               good_in = 1'b0;
            end else if (bit_one) begin
               word_in[bit_idx] = 1'b1;
            end
         end
      end
   end

   // train length and position
   always_comb begin
      total_in = total_ff;
      pos_in   = pos_ff;
      if (cmd.emit) begin
         total_in = '0;
         pos_in   = '0;
      end else begin
         if (cmd.load && first) begin
            total_in = total_eff;
         end
         if (cmd.advance) begin
            pos_in = pos_ff + 16'd1;
         end
      end
   end

   // one fnv-1a round per cycle while hash_step is set
   always_comb begin
      case (cmd.byte_sel)
         nec_ir_pkg::BSEL_CLAMP_LO: hash_byte = clamped[7:0];
         nec_ir_pkg::BSEL_CLAMP_HI: hash_byte = clamped[15:8];
         nec_ir_pkg::BSEL_MARK:     hash_byte = mark_byte_ff;
         nec_ir_pkg::BSEL_SPACE:    hash_byte = space_byte_ff;
         default:                   hash_byte = 8'h00;
      endcase
      hash_mix = hash_ff ^ {24'h000000, hash_byte};
      hash_in  = hash_ff;
      if (cmd.emit || (cmd.load && first)) begin
         hash_in = nec_ir_pkg::FNV_BASIS;
      end else if (cmd.hash_step) begin
         hash_in = hash_mix * nec_ir_pkg::FNV_PRIME;
      end
   end

   // result selection at the end of a train
   assign frame_ok = (leader_ff == LEAD_FRAME) && good_ff && (total_ff >= FRAME_PULSES) &&
                     ((~word_ff[23:16]) == word_ff[31:24]);

   always_comb begin
      kind_in     = nec_ir_pkg::KIND_NONE;
      addr_in     = '0;
      cmd_byte_in = '0;
      out_hash_in = '0;
      if (leader_ff == LEAD_REPEAT) begin
         kind_in = nec_ir_pkg::KIND_REPEAT;
      end else if (frame_ok) begin
         kind_in     = nec_ir_pkg::KIND_NEC;
         cmd_byte_in = word_ff[23:16];
         addr_in     = ((~word_ff[7:0]) == word_ff[15:8]) ? {8'h00, word_ff[7:0]}
                                                          : word_ff[15:0];
      end else if (total_ff >= RAW_MIN) begin
         kind_in     = nec_ir_pkg::KIND_RAW;
         out_hash_in = hash_ff;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         total_ff  <= '0;
         leader_ff <= LEAD_NONE;
         good_ff   <= 1'b0;
         word_ff   <= '0;
         hash_ff   <= nec_ir_pkg::FNV_BASIS;
      end else begin
         pos_ff    <= pos_in;
         total_ff  <= total_in;
         leader_ff <= leader_in;
         good_ff   <= good_in;
         word_ff   <= word_in;
         hash_ff   <= hash_in;
      end
   end

   // rounded duration bytes, taken with the request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mark_byte_ff  <= round_sat(req_mark_duration);
         space_byte_ff <= round_sat(req_space_duration);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         kind_ff     <= kind_in;
         addr_ff     <= addr_in;
         cmd_byte_ff <= cmd_byte_in;
         out_hash_ff <= out_hash_in;
      end
   end

   assign status.first_item = first;
   assign status.hash_pulse = (pos_ff < MAX_P);
   assign status.last_item  = (({1'b0, pos_ff} + 17'd1) >= {1'b0, total_ff});

   assign rsp_code_kind      = kind_ff;
   assign rsp_device_address = addr_ff;
   assign rsp_command_byte   = cmd_byte_ff;
   assign rsp_train_hash     = out_hash_ff;

endmodule

>>> design/nec_ir_pulse_decoder_core.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   mark, space, train length
// rsp       out        rsp_valid/rsp_stall   kind, address, command, hash
//
// one pulse passes an idle/accept step, two fnv-1a rounds (mark and
// space byte) through the single hash multiplier, and a closing step
// a train's first pulse adds the two clamped length-byte rounds before them
// pulses beyond MAX_PULSES skip the hash rounds and go from accept to closing
// synchronous active-high reset; all train state returns to its empty values
// a held result stalls only the closing cycle of the next train's final pulse
`include "assert_macros.svh"

module nec_ir_pulse_decoder_core #(
   parameter int unsigned MAX_PULSES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_mark_duration,
   input  logic [15:0] req_space_duration,
   input  logic [15:0] req_train_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_code_kind,
   output logic [15:0] rsp_device_address,
   output logic [7:0]  rsp_command_byte,
   output logic [31:0] rsp_train_hash
);

   nec_ir_pkg::dp_cmd_type    cmd;
   nec_ir_pkg::dp_status_type status;

   // sequencer
   nec_ir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // decode and hash datapath
   nec_ir_dpath #(
      .MAX_PULSES (MAX_PULSES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_mark_duration  (req_mark_duration),
      .req_space_duration (req_space_duration),
      .req_train_length   (req_train_length),
      .cmd                (cmd),
      .status             (status),
      .rsp_code_kind      (rsp_code_kind),
      .rsp_device_address (rsp_device_address),
      .rsp_command_byte   (rsp_command_byte),
      .rsp_train_hash     (rsp_train_hash)
   );

   // a result is only written into a free output register
   `ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit, (!rsp_valid || !rsp_stall))

   // an accepted request moves the sequencer out of idle, which stalls further requests
   `ASSERT_NEXT(a_busy_after_req, clock, reset, (req_valid && !req_stall), req_stall)

   // the hash only travels with raw results
   `ASSERT_IMPLY(a_hash_raw_only, clock, reset,
      (rsp_valid && (rsp_code_kind != nec_ir_pkg::KIND_RAW)), (rsp_train_hash == 32'd0))

endmodule
